// File: rtl/hmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap normal generator: shared definitions
// Constants, state and command types, and the normal component helper.
// ----------------------------------------------------------------------------
package hmn_pkg;

  localparam int DEF_MAX_ROW_LENGTH = 1024;
  localparam int ROW_TOTAL_LIMIT    = 1024;

  localparam int SAMPLE_W   = 8;
  localparam int CFG_LEN_W  = 11;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CELL_W     = 10;
  localparam int PROD_W     = 24;
  localparam int SQ_W       = 48;
  localparam int SUM_W      = 49;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int NUM_W      = 47;
  localparam int QUO_W      = 24;
  localparam int COMP_W     = 16;
  localparam int TDATA_W    = 96;
  localparam int HT_W       = 25;
  localparam int HPROD_W    = 51;
  localparam int HEIGHT_SHIFT = 33;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

  // The vertical part of the scaled vector is 2 * 255; its square is fixed.
  localparam logic [PROD_W-1:0] FLAT_Y    = 24'd510;
  localparam logic [SUM_W-1:0]  FLAT_Y_SQ = 49'd260100;
  // The height is hp + (hp + 127) / 255, the division done by multiplying
  // with ceil(2^33 / 255), which is exact for every dividend below 2^25.
  localparam logic [HT_W-1:0]   HEIGHT_ROUND = 25'd127;
  localparam logic [HT_W:0]     HEIGHT_RECIP = 26'd33686019;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_MUL1, ST_MUL2, ST_SUM,
    ST_SQRT_GO, ST_SQRT_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {DIV_H, DIV_X, DIV_Y, DIV_Z} div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     rd0;
    logic     rd1;
    logic     rd2;
    logic     mul1;
    logic     mul2;
    logic     sum;
    logic     sqrt_start;
    logic     div_start;
    logic     div_capture;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } status_t;

  // Saturates a quotient to the Q1.15 maximum and applies the sign.
  function automatic logic [COMP_W-1:0] make_component(input logic sat,
                                                       input logic [14:0] q,
                                                       input logic neg);
    logic [COMP_W-1:0] m;
    m = sat ? 16'd32767 : {1'b0, q};
    return neg ? (~m + 16'd1) : m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hmn_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap normal generator: integer square root
// Restoring square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module hmn_sqrt
  import hmn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic      [ROOT_W-1:0] root,
  output logic                   done
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        cnt <= cnt + CNT_W'(1);
        if (rem_sh >= trial) begin
          rem  <= (ROOT_W+2)'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/hmn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap normal generator: shared divider
// Restoring long division, one numerator bit per cycle. Only quotients that
// fit the result width are ever asked for.
// ----------------------------------------------------------------------------
module hmn_div
  import hmn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [ROOT_W-1:0] den,
  output logic      [QUO_W-1:0]  quo,
  output logic                   done
);

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  nreg;
  logic [ROOT_W-1:0] dreg;
  logic [ROOT_W-1:0] rem;
  logic [ROOT_W:0]   rem_sh;

  assign rem_sh = {rem, nreg[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nreg <= num;
        dreg <= den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        nreg <= {nreg[NUM_W-2:0], 1'b0};
        cnt  <= cnt + CNT_W'(1);
        if (rem_sh >= {1'b0, dreg}) begin
          rem <= ROOT_W'(rem_sh - {1'b0, dreg});
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[ROOT_W-1:0];
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/hmn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap normal generator: datapath
// Configuration, frame counters, the two line stores, multipliers, the
// square root and divider units, and the output register.
// ----------------------------------------------------------------------------
module hmn_datapath
  import hmn_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [TDATA_W-1:0]    m_tdata,
  output logic                       m_tlast
);

  localparam int IDX_W = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

  // Configuration and frame position.
  logic [CFG_LEN_W-1:0] row_length;
  logic [CFG_LEN_W-1:0] row_total;
  logic [SCALE_W-1:0]   height_scale;
  logic [IDX_W-1:0]     column_count;
  logic [CFG_LEN_W-1:0] row_count;

  logic [CMP_W-1:0]     rl_ext;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     len_m1;
  logic [CFG_LEN_W-1:0] tot;
  logic [IDX_W-1:0]     x_cur;
  logic [CFG_LEN_W-1:0] rc_cur;
  logic                 col_last;
  logic                 flush_row;

  // Item under work.
  logic [IDX_W-1:0]     x_reg;
  logic [CFG_LEN_W-1:0] rc_reg;
  logic [SAMPLE_W-1:0]  sample;
  logic                 x_pos;
  logic                 has_right;
  logic                 r_pos;
  logic                 frame_last;
  logic [SAMPLE_W-1:0]  center;
  logic [SAMPLE_W-1:0]  sb;
  logic [SAMPLE_W-1:0]  sl;
  logic [SAMPLE_W-1:0]  sr;

  // Line stores.
  logic [SAMPLE_W-1:0] prior_mem [MAX_ROW_LENGTH];
  logic [SAMPLE_W-1:0] older_mem [MAX_ROW_LENGTH];
  logic [SAMPLE_W-1:0] prior_rd;
  logic [SAMPLE_W-1:0] older_rd;
  logic [IDX_W-1:0]    prior_addr;
  logic [IDX_W-1:0]    older_addr;

  // Arithmetic.
  logic [SAMPLE_W-1:0] dx;
  logic [SAMPLE_W-1:0] dz;
  logic                nx_neg;
  logic                nz_neg;
  logic [PROD_W-1:0]   ax;
  logic [PROD_W-1:0]   az;
  logic [PROD_W-1:0]   hp;
  logic [HT_W-1:0]     ht;
  logic [HPROD_W-1:0]  hprod;
  logic [SQ_W-1:0]     ax2;
  logic [SQ_W-1:0]     az2;
  logic [SUM_W-1:0]    ssum;
  logic [ROOT_W-1:0]   root;
  logic [PROD_W-1:0]   mag;
  logic [NUM_W-1:0]    num;
  logic [ROOT_W-1:0]   den;
  logic                sat;
  logic [QUO_W-1:0]    quo;
  logic [QUO_W-1:0]    qh;
  logic [COMP_W-1:0]   nx;
  logic [COMP_W-1:0]   ny;
  logic [COMP_W-1:0]   nz;

  // Output register.
  logic [CELL_W-1:0]   out_col;
  logic [CELL_W-1:0]   out_row;
  logic [QUO_W-1:0]    out_h;
  logic [COMP_W-1:0]   out_nx;
  logic [COMP_W-1:0]   out_ny;
  logic [COMP_W-1:0]   out_nz;

  // Effective row length and row count, with out-of-range values clamped.
  always_comb begin
    rl_ext = CMP_W'(row_length);
    if (rl_ext == '0) begin
      len = LEN_W'(1);
    end else if (rl_ext > CMP_W'(MAX_ROW_LENGTH)) begin
      len = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len = LEN_W'(rl_ext);
    end
    len_m1 = len - LEN_W'(1);
    if (row_total == '0) begin
      tot = CFG_LEN_W'(1);
    end else if (row_total > CFG_LEN_W'(ROW_TOTAL_LIMIT)) begin
      tot = CFG_LEN_W'(ROW_TOTAL_LIMIT);
    end else begin
      tot = row_total;
    end
    x_cur     = (LEN_W'(column_count) > len_m1) ? IDX_W'(len_m1) : column_count;
    rc_cur    = (row_count > tot) ? tot : row_count;
    col_last  = (LEN_W'(x_cur) == len_m1);
    flush_row = (rc_cur == tot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= CFG_LEN_W'(1);
      row_total    <= CFG_LEN_W'(1);
      height_scale <= SCALE_W'(1);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH: begin
          row_length   <= cfg_data[CFG_LEN_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        REG_ROW_TOTAL: begin
          row_total    <= cfg_data[CFG_LEN_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        REG_HEIGHT_SCALE: begin
          height_scale <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= flush_row ? '0 : rc_cur + CFG_LEN_W'(1);
      end else begin
        column_count <= x_cur + IDX_W'(1);
      end
    end
  end

  // Item capture; the flush row reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg      <= x_cur;
      rc_reg     <= rc_cur;
      sample     <= flush_row ? '0 : s_tdata;
      x_pos      <= (x_cur != '0);
      has_right  <= !col_last;
      r_pos      <= (rc_cur > CFG_LEN_W'(1));
      frame_last <= col_last && flush_row;
    end
    if (cmd.rd1) begin
      center <= prior_rd;
      sb     <= r_pos ? older_rd : '0;
    end
    if (cmd.rd2) begin
      sr <= has_right ? prior_rd : '0;
      sl <= x_pos ? older_rd : '0;
    end
  end

  // The centre and the cell below are read first, the side neighbours next.
  assign prior_addr = cmd.rd0 ? x_reg : x_reg + IDX_W'(1);
  assign older_addr = cmd.rd0 ? x_reg : x_reg - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd2) begin
      prior_mem[x_reg] <= sample;
      older_mem[x_reg] <= center;
    end
    prior_rd <= prior_mem[prior_addr];
    older_rd <= older_mem[older_addr];
  end

  assign dx = (sl < sr) ? sr - sl : sl - sr;
  assign dz = (sb < sample) ? sample - sb : sb - sample;

  assign ht    = HT_W'(hp) + HEIGHT_ROUND;
  assign hprod = HPROD_W'(ht) * HPROD_W'(HEIGHT_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      nx_neg <= (sl < sr);
      nz_neg <= (sb < sample);
      ax     <= PROD_W'(dx) * PROD_W'(height_scale);
      az     <= PROD_W'(dz) * PROD_W'(height_scale);
      hp     <= PROD_W'(center) * PROD_W'(height_scale);
    end
    if (cmd.mul2) begin
      ax2 <= SQ_W'(ax) * SQ_W'(ax);
      az2 <= SQ_W'(az) * SQ_W'(az);
      qh  <= hp + QUO_W'(hprod >> HEIGHT_SHIFT);
    end
    if (cmd.sum) begin
      ssum <= SUM_W'(ax2) + SUM_W'(az2) + FLAT_Y_SQ;
    end
  end

  hmn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (RAD_W'({ssum, 14'b0})),
    .root     (root),
    .done     (status.sqrt_done)
  );

  // Divider operands: each normal component divides by the root.
  always_comb begin
    case (cmd.div_sel)
      DIV_X:   mag = ax;
      DIV_Y:   mag = FLAT_Y;
      DIV_Z:   mag = az;
      default: mag = '0;
    endcase
    num = NUM_W'({mag, 22'b0}) + NUM_W'(root[ROOT_W-1:1]);
    den = root;
    sat = (num >= NUM_W'({root, 15'b0}));
  end

  hmn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (status.div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_sel)
        DIV_X:   nx <= make_component(sat, quo[14:0], nx_neg);
        DIV_Y:   ny <= make_component(sat, quo[14:0], 1'b0);
        DIV_Z:   nz <= make_component(sat, quo[14:0], nz_neg);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col <= CELL_W'(x_reg);
      out_row <= CELL_W'(rc_reg - CFG_LEN_W'(1));
      out_h   <= qh;
      out_nx  <= nx;
      out_ny  <= ny;
      out_nz  <= nz;
      m_tlast <= frame_last;
    end
  end

  assign m_tdata = {4'b0, out_nz, out_ny, out_nx, out_h, out_row, out_col};

  assign status.has_result = (rc_reg != '0);
  assign status.out_free   = !m_tvalid || m_tready;

endmodule
`default_nettype wire

// File: rtl/hmn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap normal generator: controller
// Sequences line store reads, multiplies, the root and three divisions.
// ----------------------------------------------------------------------------
module hmn_ctrl
  import hmn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t   state;
  state_t   state_next;
  div_sel_t div_idx;
  div_sel_t div_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_idx <= DIV_H;
    end else begin
      state   <= state_next;
      div_idx <= div_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_idx_next = div_idx;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_RD0;
      ST_RD0:       state_next = ST_RD1;
      ST_RD1:       state_next = ST_RD2;
      ST_RD2:       state_next = status.has_result ? ST_MUL1 : ST_IDLE;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_SUM;
      ST_SUM:       state_next = ST_SQRT_GO;
      ST_SQRT_GO: begin
        state_next   = ST_SQRT_WAIT;
        div_idx_next = DIV_X;
      end
      ST_SQRT_WAIT: if (status.sqrt_done) state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (div_idx == DIV_Z) begin
            state_next = ST_OUT;
          end else begin
            state_next   = ST_DIV_GO;
            div_idx_next = div_sel_t'(div_idx + 2'd1);
          end
        end
      end
      ST_OUT:       if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = (state == ST_IDLE);
    cmd             = '0;
    cmd.div_sel     = div_idx;
    cmd.accept      = (state == ST_IDLE) && s_tvalid;
    cmd.rd0         = (state == ST_RD0);
    cmd.rd1         = (state == ST_RD1);
    cmd.rd2         = (state == ST_RD2);
    cmd.mul1        = (state == ST_MUL1);
    cmd.mul2        = (state == ST_MUL2);
    cmd.sum         = (state == ST_SUM);
    cmd.sqrt_start  = (state == ST_SQRT_GO);
    cmd.div_start   = (state == ST_DIV_GO);
    cmd.div_capture = (state == ST_DIV_WAIT) && status.div_done;
    cmd.out_load    = (state == ST_OUT) && status.out_free;
  end

endmodule
`default_nettype wire

// File: rtl/heightmap_normal_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap normal generator
// Scales raster-order height samples and emits each cell's height and unit
// normal one row behind the input.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  cfg      in         cfg_index selects row_length, row_total, height_scale
//  s        in         s_tdata: height_sample
//  m        out        m_tdata: cell position, scaled height, normal; m_tlast
//
//  An item of the first grid row is only read and stored; any other item
//  also runs the multiplies, the 32-step square root and three 47-step
//  divisions that share one divider, then waits for a free output.
//  One item is worked at a time; a finished result waits in the output
//  register while the next sample is taken. Reset is synchronous and
//  leaves the line stores as they are. A stalled output holds the
//  controller before its next result load only.
// ----------------------------------------------------------------------------
module heightmap_normal_generator
  import hmn_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,   // height_sample
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // cell_column, cell_row, scaled_height, normal_x, normal_y, normal_z, pad
  output logic      [TDATA_W-1:0]    m_tdata,
  output logic                       m_tlast    // frame_end
);

  cmd_t    cmd;
  status_t status;

  hmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hmn_datapath #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second sample taken while one is in work");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a waiting result");
  a_div_lat: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider finished too early");
  a_sqrt_lat: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |=> !status.sqrt_done)
    else $error("square root finished too early");
`endif

endmodule
`default_nettype wire
